// ===== rtl/core/edlb_pkg.sv =====
// ----------------------------------------------------------------------------
// edlb_pkg
// Shared types and constants for the echo distance LED bar.
// ----------------------------------------------------------------------------
package edlb_pkg;

    localparam int unsigned STAMP_W    = 16;
    localparam int unsigned DIST_W     = 11;
    localparam int unsigned IDLE_W     = 5;
    localparam int unsigned LED_W      = 6;
    localparam int unsigned OFFCNT_W   = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_DATA_W   = 16;
    localparam int unsigned M_DATA_W   = 40;

    // ticks / 58 == (ticks >> 1) / 29, exact for 15-bit values with this reciprocal
    localparam int unsigned DIV_SHIFT  = 20;
    localparam int unsigned PROD_W     = 31;
    localparam logic [15:0] DIV29_MULT = 16'd36158;

    localparam logic [IDLE_W-1:0] IDLE_SAT = 5'd17;

    localparam logic [LED_W-1:0] LEDS_OFF   = 6'h00;
    localparam logic [LED_W-1:0] LEDS_RED   = 6'h01;
    localparam logic [LED_W-1:0] LEDS_FIVE  = 6'h3E;
    localparam logic [LED_W-1:0] LEDS_FOUR  = 6'h3C;
    localparam logic [LED_W-1:0] LEDS_THREE = 6'h38;
    localparam logic [LED_W-1:0] LEDS_TWO   = 6'h28;
    localparam logic [LED_W-1:0] LEDS_ONE   = 6'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNTER_TOP    = 3'd0,
        REG_RED_LIMIT      = 3'd1,
        REG_BAND_ONE       = 3'd2,
        REG_BAND_TWO       = 3'd3,
        REG_BAND_THREE     = 3'd4,
        REG_BAND_FOUR      = 3'd5,
        REG_FAR_LIMIT      = 3'd6,
        REG_IDLE_OFF_COUNT = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [STAMP_W-1:0]  counter_top;
        logic [DIST_W-1:0]   red_limit_cm;
        logic [DIST_W-1:0]   band_one_cm;
        logic [DIST_W-1:0]   band_two_cm;
        logic [DIST_W-1:0]   band_three_cm;
        logic [DIST_W-1:0]   band_four_cm;
        logic [DIST_W-1:0]   far_limit_cm;
        logic [OFFCNT_W-1:0] idle_off_count;
    } cfg_t;

    typedef struct packed {
        logic [IDLE_W-1:0] idle_count;
        logic [LED_W-1:0]  led_pattern;
    } bar_state_t;

endpackage

// ===== rtl/core/edlb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// edlb_cfg_regs
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module edlb_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [edlb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [edlb_pkg::CFG_DATA_W-1:0] cfg_data,
    output edlb_pkg::cfg_t                  cfg
);
    import edlb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_COUNTER_TOP:    cfg_next.counter_top    = cfg_data;
                REG_RED_LIMIT:      cfg_next.red_limit_cm   = cfg_data[DIST_W-1:0];
                REG_BAND_ONE:       cfg_next.band_one_cm    = cfg_data[DIST_W-1:0];
                REG_BAND_TWO:       cfg_next.band_two_cm    = cfg_data[DIST_W-1:0];
                REG_BAND_THREE:     cfg_next.band_three_cm  = cfg_data[DIST_W-1:0];
                REG_BAND_FOUR:      cfg_next.band_four_cm   = cfg_data[DIST_W-1:0];
                REG_FAR_LIMIT:      cfg_next.far_limit_cm   = cfg_data[DIST_W-1:0];
                REG_IDLE_OFF_COUNT: cfg_next.idle_off_count = cfg_data[OFFCNT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.counter_top    <= 16'd65000;
            cfg_reg.red_limit_cm   <= 11'd18;
            cfg_reg.band_one_cm    <= 11'd25;
            cfg_reg.band_two_cm    <= 11'd40;
            cfg_reg.band_three_cm  <= 11'd60;
            cfg_reg.band_four_cm   <= 11'd80;
            cfg_reg.far_limit_cm   <= 11'd400;
            cfg_reg.idle_off_count <= 4'd15;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/edlb_range_calc.sv =====
// ----------------------------------------------------------------------------
// edlb_range_calc
// Echo width from two stamps (one wrap corrected) and width / 58.
// ----------------------------------------------------------------------------
module edlb_range_calc (
    input  logic [edlb_pkg::STAMP_W-1:0] first_stamp,
    input  logic [edlb_pkg::STAMP_W-1:0] second_stamp,
    input  logic [edlb_pkg::STAMP_W-1:0] counter_top,
    output logic [edlb_pkg::STAMP_W-1:0] raw_ticks,
    output logic [edlb_pkg::DIST_W-1:0]  distance_cm
);
    import edlb_pkg::*;

    logic signed [STAMP_W+1:0] wrap_sum;
    logic [STAMP_W-2:0]        half_ticks;
    logic [PROD_W-1:0]         quot_prod;

    // wrapped width: top - first + 1 + second, clamped to 0..65535
    assign wrap_sum = $signed({2'b00, counter_top}) - $signed({2'b00, first_stamp})
                    + $signed({2'b00, second_stamp}) + 18'sd1;

    always_comb begin
        if (second_stamp > first_stamp) begin
            raw_ticks = second_stamp - first_stamp;
        end else if (wrap_sum < 0) begin
            raw_ticks = '0;
        end else if (wrap_sum[STAMP_W+1:STAMP_W] != 2'b00) begin
            raw_ticks = '1;
        end else begin
            raw_ticks = wrap_sum[STAMP_W-1:0];
        end
    end

    assign half_ticks  = raw_ticks[STAMP_W-1:1];
    assign quot_prod   = PROD_W'(half_ticks) * PROD_W'(DIV29_MULT);
    assign distance_cm = quot_prod[DIV_SHIFT +: DIST_W];

endmodule

// ===== rtl/core/edlb_bar_logic.sv =====
// ----------------------------------------------------------------------------
// edlb_bar_logic
// Idle counting and LED bar pattern selection.
// ----------------------------------------------------------------------------
module edlb_bar_logic (
    input  logic [edlb_pkg::DIST_W-1:0] distance_cm,
    input  logic [edlb_pkg::DIST_W-1:0] prev_distance,
    input  edlb_pkg::bar_state_t        bar_cur,
    input  edlb_pkg::cfg_t              cfg,
    output edlb_pkg::bar_state_t        bar_next
);
    import edlb_pkg::*;

    logic [DIST_W:0]   dist_x;
    logic [DIST_W:0]   prev_x;
    logic              still;
    logic [IDLE_W-1:0] idle_new;
    logic [IDLE_W-1:0] off_count_x;
    logic [LED_W-1:0]  band_led;

    assign dist_x      = {1'b0, distance_cm};
    assign prev_x      = {1'b0, prev_distance};
    assign still       = (prev_x == dist_x) || (prev_x == dist_x + 12'd1)
                      || (prev_x + 12'd1 == dist_x);
    assign off_count_x = {1'b0, cfg.idle_off_count};

    always_comb begin
        if (!still) begin
            idle_new = '0;
        end else if (bar_cur.idle_count < IDLE_SAT) begin
            idle_new = bar_cur.idle_count + 5'd1;
        end else begin
            idle_new = bar_cur.idle_count;
        end
    end

    // first matching band wins, whatever the threshold order
    always_comb begin
        if (distance_cm >= cfg.far_limit_cm) begin
            band_led = LEDS_OFF;
        end else if (distance_cm <= cfg.red_limit_cm) begin
            band_led = LEDS_RED;
        end else if (distance_cm <= cfg.band_one_cm) begin
            band_led = LEDS_FIVE;
        end else if (distance_cm <= cfg.band_two_cm) begin
            band_led = LEDS_FOUR;
        end else if (distance_cm <= cfg.band_three_cm) begin
            band_led = LEDS_THREE;
        end else if (distance_cm <= cfg.band_four_cm) begin
            band_led = LEDS_TWO;
        end else begin
            band_led = LEDS_ONE;
        end
    end

    always_comb begin
        bar_next.idle_count = idle_new;
        if (idle_new > off_count_x) begin
            bar_next.led_pattern = bar_cur.led_pattern;
        end else if (idle_new == off_count_x) begin
            bar_next.led_pattern = LEDS_OFF;
        end else begin
            bar_next.led_pattern = band_led;
        end
    end

endmodule

// ===== rtl/core/echo_distance_led_bar.sv =====
// ----------------------------------------------------------------------------
// echo_distance_led_bar
// Echo ranging from capture stamps, with a six-LED distance bar.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata[15:0] capture_time
//  m_      | out | m_tvalid/m_tready  | m_tdata: raw_ticks, distance_cm,
//          |     |                    |          idle_count, led_pattern
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
//  One item per cycle while m_tready is high; a falling stamp passes from s_
//  accept through the input register, then the result register, to m_tvalid.
//  Stamps alternate rising/falling; a rising stamp only stores state and
//  yields no result. Reset (aresetn low, synchronous) clears phase, first
//  stamp, idle count, LEDs and loads config defaults.
//  While m_tready is low the result holds; the input register still takes one
//  more item, and rising stamps keep draining since they give no result.
//
module echo_distance_led_bar (
    input  logic                            aclk,
    input  logic                            aresetn,
    // slave side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [edlb_pkg::S_DATA_W-1:0]   s_tdata,  // [15:0] capture_time
    // master side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [edlb_pkg::M_DATA_W-1:0]   m_tdata,  // [15:0] raw_ticks,
                                                      // [26:16] distance_cm,
                                                      // [31:27] idle_count,
                                                      // [37:32] led_pattern,
                                                      // [39:38] zero
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [edlb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [edlb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import edlb_pkg::*;

    cfg_t cfg;

    // input register
    logic               in_valid_reg, in_valid_next;
    logic [STAMP_W-1:0] in_stamp_reg;

    // ranging state
    logic               phase_reg, phase_next;      // 1: expecting falling edge
    logic [STAMP_W-1:0] first_stamp_reg;
    logic [DIST_W-1:0]  prev_dist_reg;
    bar_state_t         bar_reg, bar_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [STAMP_W-1:0] out_ticks_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    bar_state_t         out_bar_reg;

    logic               advance;
    logic               s_accept;
    logic [STAMP_W-1:0] raw_ticks;
    logic [DIST_W-1:0]  distance_cm;

    assign cfg_ready = 1'b1;

    edlb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    edlb_range_calc u_range (
        .first_stamp  (first_stamp_reg),
        .second_stamp (in_stamp_reg),
        .counter_top  (cfg.counter_top),
        .raw_ticks    (raw_ticks),
        .distance_cm  (distance_cm)
    );

    edlb_bar_logic u_bar (
        .distance_cm   (distance_cm),
        .prev_distance (prev_dist_reg),
        .bar_cur       (bar_reg),
        .cfg           (cfg),
        .bar_next      (bar_next)
    );

    // a rising stamp never needs the result slot
    assign advance  = in_valid_reg & (~phase_reg | ~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;

    always_comb begin
        in_valid_next = s_accept | (in_valid_reg & ~advance);
        phase_next    = advance ? ~phase_reg : phase_reg;

        out_valid_next = out_valid_reg & ~m_tready;
        if (advance && phase_reg) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            phase_reg       <= 1'b0;
            first_stamp_reg <= '0;
            prev_dist_reg   <= '0;
            bar_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (advance && !phase_reg) begin
                first_stamp_reg <= in_stamp_reg;
            end
            if (advance && phase_reg) begin
                prev_dist_reg <= distance_cm;
                bar_reg       <= bar_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_stamp_reg <= s_tdata[STAMP_W-1:0];
        end
        if (advance && phase_reg) begin
            out_ticks_reg <= raw_ticks;
            out_dist_reg  <= distance_cm;
            out_bar_reg   <= bar_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_bar_reg.led_pattern, out_bar_reg.idle_count,
                       out_dist_reg, out_ticks_reg};

endmodule

// ===== rtl/core/edlb_checker.sv =====
// ----------------------------------------------------------------------------
// edlb_checker
// Port-level checks for the echo distance LED bar, bound to the top level.
// ----------------------------------------------------------------------------
module edlb_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [edlb_pkg::M_DATA_W-1:0]   m_tdata
);
    import edlb_pkg::*;

    logic [LED_W-1:0]  led_f;
    logic [IDLE_W-1:0] idle_f;
    logic [DIST_W-1:0] dist_f;

    assign led_f  = m_tdata[37:32];
    assign idle_f = m_tdata[31:27];
    assign dist_f = m_tdata[26:16];

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_idle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> idle_f <= IDLE_SAT && dist_f <= 11'd1129)
        else $error("idle count or distance out of range");

    a_led_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (led_f == LEDS_OFF) || (led_f == LEDS_RED) ||
                     (led_f == LEDS_FIVE) || (led_f == LEDS_FOUR) ||
                     (led_f == LEDS_THREE) || (led_f == LEDS_TWO) ||
                     (led_f == LEDS_ONE))
        else $error("illegal LED pattern");

endmodule

bind echo_distance_led_bar edlb_checker u_edlb_checker (.*);
